FILE: hdl/fsbm_pkg.sv
// Shared constants, codes and types of the scrolling background mixer.
package fsbm_pkg;

  // Item opcodes
  localparam logic [2:0] OP_LATCH = 3'd0;
  localparam logic [2:0] OP_GFX   = 3'd1;
  localparam logic [2:0] OP_MIXER = 3'd2;
  localparam logic [2:0] OP_LINE  = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam int LAYERS      = 4;
  localparam int BANK_AW     = 13;   // one graphics bank of 8192 bytes per layer
  localparam int LATCH_COUNT = 13;
  localparam logic [3:0] LATCH_BANKS = 4'd12;  // mixer bank low, palette bank high
  localparam logic [3:0] LATCH_LAST  = 4'd12;

  // Output word queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // Upper bits of every pen index
  localparam logic [1:0] PEN_BASE_HI = 2'b10;

  // Per-tick information handed from the fetch stage to the mixer
  typedef struct packed {
    logic       valid;      // tick that gives a word
    logic [3:0] en;         // layer inside its window
    logic [3:0] dark;       // column beyond the bitmap
    logic [7:0] sub;        // pixel position within the byte, two bits per layer
    logic [3:0] mix_bank;
    logic [3:0] pal_bank;
  } tick_t;

endpackage

FILE: hdl/four_layer_scroll_background_mixer.sv
// Top level of the four-layer scrolling background mixer.
// Takes one item every cycle while input is not held off, pixel ticks included, so
// a raster runs at one pixel per clock; a pen word comes from the registered read
// of the four graphics banks (one per layer, read in parallel) followed by the
// registered mixer PROM read. Words wait in a four-entry queue, and input is
// held off only when that queue and the words in flight would overflow it. Graphics
// and mixer memories need no clearing pass: an unwritten entry reads as anything.
// flip_screen is written through its own port, accepted every cycle.
module four_layer_scroll_background_mixer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        flip_screen,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [3:0]  latch_select,
  input  logic [14:0] mem_address,
  input  logic [7:0]  write_data,
  input  logic        emit_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  pen_index
);

  logic [7:0] latches   [fsbm_pkg::LATCH_COUNT];
  logic [7:0] x_cnt     [fsbm_pkg::LAYERS];
  logic [4:0] start_cnt [fsbm_pkg::LAYERS];
  logic [4:0] stop_cnt  [fsbm_pkg::LAYERS];
  logic [7:0] x_next     [fsbm_pkg::LAYERS];
  logic [4:0] start_next [fsbm_pkg::LAYERS];
  logic [4:0] stop_next  [fsbm_pkg::LAYERS];
  logic       flip;

  logic [fsbm_pkg::BANK_AW-1:0] rom_raddr [fsbm_pkg::LAYERS];
  logic [7:0]                   rom_q     [fsbm_pkg::LAYERS];
  logic [3:0]                   rom_we;

  fsbm_pkg::tick_t tick_next;
  fsbm_pkg::tick_t tick;

  logic                          accept;
  logic                          is_tick;
  logic                          pen_valid;
  logic [9:0]                    pen;
  logic [fsbm_pkg::QUEUE_CW-1:0] q_count;
  logic [fsbm_pkg::QUEUE_CW-1:0] in_flight;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign is_tick   = accept && (opcode == fsbm_pkg::OP_TICK);

  // Hold off input while queued and in-flight words would fill the queue
  assign in_flight = q_count + {{(fsbm_pkg::QUEUE_CW-1){1'b0}}, tick.valid}
                             + {{(fsbm_pkg::QUEUE_CW-1){1'b0}}, pen_valid};
  assign in_ready  = (in_flight < fsbm_pkg::QUEUE_CW'(fsbm_pkg::QUEUE_DEPTH));

  // Flip register
  always_ff @(posedge clk) begin
    if (rst) begin
      flip <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      flip <= flip_screen;
    end
  end

  // Scroll and window latches
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsbm_pkg::LATCH_COUNT; i++) begin
        latches[i] <= 8'd0;
      end
    end else if (accept && opcode == fsbm_pkg::OP_LATCH
                 && latch_select <= fsbm_pkg::LATCH_LAST) begin
      latches[latch_select] <= write_data;
    end
  end

  // Next counter values: load at line start, step on every pixel tick
  always_comb begin
    for (int i = 0; i < fsbm_pkg::LAYERS; i++) begin
      logic wrap;
      x_next[i]     = x_cnt[i];
      start_next[i] = start_cnt[i];
      stop_next[i]  = stop_cnt[i];
      wrap          = 1'b0;
      if (!flip) begin
        x_next[i] = x_cnt[i] + 8'd1;
        wrap      = (x_next[i][4:0] == 5'd0);
      end else begin
        wrap      = (x_cnt[i][4:0] == 5'd0);
        x_next[i] = x_cnt[i] - 8'd1;
      end
      if (wrap) begin
        start_next[i] = start_cnt[i] + 5'd1;
        stop_next[i]  = stop_cnt[i] + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsbm_pkg::LAYERS; i++) begin
        x_cnt[i]     <= 8'd0;
        start_cnt[i] <= 5'd0;
        stop_cnt[i]  <= 5'd0;
      end
    end else if (accept && opcode == fsbm_pkg::OP_LINE) begin
      for (int i = 0; i < fsbm_pkg::LAYERS; i++) begin
        x_cnt[i]     <= latches[2*i];
        start_cnt[i] <= {1'b0, latches[8+i][3:0]};
        stop_cnt[i]  <= {1'b0, latches[8+i][7:4]};
      end
    end else if (is_tick) begin
      for (int i = 0; i < fsbm_pkg::LAYERS; i++) begin
        x_cnt[i]     <= x_next[i];
        start_cnt[i] <= start_next[i];
        stop_cnt[i]  <= stop_next[i];
      end
    end
  end

  // Fetch addresses and per-tick information for the mixer
  always_comb begin
    for (int i = 0; i < fsbm_pkg::LAYERS; i++) begin
      rom_raddr[i] = {latches[2*i+1], x_cnt[i][6:2]};
      rom_we[i]    = accept && (opcode == fsbm_pkg::OP_GFX) && (mem_address[14:13] == 2'(i));
      tick_next.en[i]         = start_cnt[i][4] ^ stop_cnt[i][4];
      tick_next.dark[i]       = x_cnt[i][7];
      tick_next.sub[2*i +: 2] = x_cnt[i][1:0];
    end
    tick_next.valid    = is_tick && emit_pixel;
    tick_next.mix_bank = latches[fsbm_pkg::LATCH_BANKS][3:0];
    tick_next.pal_bank = latches[fsbm_pkg::LATCH_BANKS][7:4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
    end else begin
      tick <= tick_next;
    end
  end

  // One graphics bank per layer
  for (genvar g = 0; g < fsbm_pkg::LAYERS; g++) begin : g_bank
    fsbm_gfx_bank u_bank (
      .clk   (clk),
      .we    (rom_we[g]),
      .waddr (mem_address[fsbm_pkg::BANK_AW-1:0]),
      .wdata (write_data),
      .raddr (rom_raddr[g]),
      .rdata (rom_q[g])
    );
  end

  fsbm_mixer u_mixer (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .rom_data   (rom_q),
    .prom_we    (accept && opcode == fsbm_pkg::OP_MIXER),
    .prom_waddr (mem_address[7:0]),
    .prom_wdata (write_data[1:0]),
    .pen_valid  (pen_valid),
    .pen        (pen)
  );

  fsbm_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pen_valid),
    .push_data (pen),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pen_index (pen_index),
    .count     (q_count)
  );

endmodule

FILE: hdl/fsbm_gfx_bank.sv
// One layer's graphics bank: 8192 bytes, one write port, one registered read port.
module fsbm_gfx_bank (
  input  logic                        clk,
  input  logic                        we,
  input  logic [fsbm_pkg::BANK_AW-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic [fsbm_pkg::BANK_AW-1:0] raddr,
  output logic [7:0]                  rdata
);

  logic [7:0] mem [2**fsbm_pkg::BANK_AW];

  // Write and read in the same clocked block, old data on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/fsbm_mixer.sv
// Pixel decode, mixer PROM lookup and pen assembly.
module fsbm_mixer (
  input  logic              clk,
  input  logic              rst,
  input  fsbm_pkg::tick_t   tick,
  input  logic [7:0]        rom_data [fsbm_pkg::LAYERS],
  input  logic              prom_we,
  input  logic [7:0]        prom_waddr,
  input  logic [1:0]        prom_wdata,
  output logic              pen_valid,
  output logic [9:0]        pen
);

  logic [1:0] prom [256];
  logic [1:0] prom_q;
  logic [7:0] pixels;
  logic [3:0] flags;
  logic [7:0] s2_pixels;
  logic [3:0] s2_pal;
  logic       s2_valid;
  logic [1:0] sel_px;

  // Decode each layer's pixel: high bit from the upper nibble, low bit from the lower
  always_comb begin
    for (int i = 0; i < fsbm_pkg::LAYERS; i++) begin
      logic [1:0] s;
      logic [1:0] p;
      s = tick.sub[2*i +: 2];
      p = {rom_data[i][{1'b1, s}], rom_data[i][{1'b0, s}]};
      if (!tick.en[i] || tick.dark[i]) begin
        p = 2'd0;
      end
      pixels[2*i +: 2] = p;
      flags[i] = (p != 2'd0);
    end
  end

  // Look up the selected layer; a write in the same cycle lands after the read
  always_ff @(posedge clk) begin
    if (prom_we) begin
      prom[prom_waddr] <= prom_wdata;
    end
    prom_q    <= prom[{tick.mix_bank, flags}];
    s2_pixels <= pixels;
    s2_pal    <= tick.pal_bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= tick.valid;
    end
  end

  // Assemble the pen from palette bank, layer and its pixel
  assign sel_px    = s2_pixels[{prom_q, 1'b0} +: 2];
  assign pen       = {fsbm_pkg::PEN_BASE_HI, s2_pal, prom_q, sel_px};
  assign pen_valid = s2_valid;

endmodule

FILE: hdl/fsbm_out_queue.sv
// Output word queue that decouples the pipeline from the consumer.
module fsbm_out_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [9:0]                    push_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [9:0]                    pen_index,
  output logic [fsbm_pkg::QUEUE_CW-1:0] count
);

  logic [9:0]                    mem [fsbm_pkg::QUEUE_DEPTH];
  logic [fsbm_pkg::QUEUE_AW-1:0] wptr;
  logic [fsbm_pkg::QUEUE_AW-1:0] rptr;
  logic                          pop;

  assign out_valid = (count != '0);
  assign pen_index = mem[rptr];
  assign pop       = out_valid && out_ready;

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
